/* rtl/bfsp_pkg.sv */
// Package for the Bellman-Ford shortest path unit.
// Holds the fixed sizes, opcodes, sequencer states and payload structs.
// No dependencies.
package bfsp_pkg;

    localparam int NUM_VERTICES = 16;
    localparam int VERT_BITS    = 4;
    localparam int EDGE_BITS    = 2 * VERT_BITS;
    localparam int NUM_EDGES    = NUM_VERTICES * NUM_VERTICES;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 24;

    localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic                          opcode;
        logic [VERT_BITS-1:0]          row;
        logic [VERT_BITS-1:0]          col;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic [VERT_BITS-1:0]          source_vertex;
    } in_item_t;

    typedef struct packed {
        logic [VERT_BITS-1:0]        vertex;
        logic signed [DIST_BITS-1:0] distance;
        logic                        reachable;
        logic [VERT_BITS-1:0]        parent;
        logic                        has_parent;
        logic                        negative_cycle;
        logic                        last;
    } out_item_t;

    typedef struct packed {
        logic                        improve;
        logic signed [DIST_BITS-1:0] cand;
    } alu_result_t;

endpackage

/* rtl/bfsp_alu.sv */
// Shared relaxation unit: saturating distance add and improvement compare.
// Depends on bfsp_pkg.
module bfsp_alu (
    input  logic signed [bfsp_pkg::DIST_BITS-1:0]   dist_a,
    input  logic signed [bfsp_pkg::DIST_BITS-1:0]   dist_b,
    input  logic signed [bfsp_pkg::WEIGHT_BITS-1:0] weight,
    input  logic                                    edge_ok,
    input  logic                                    reach_b,
    output bfsp_pkg::alu_result_t                   result
);

    localparam int SUM_BITS = bfsp_pkg::DIST_BITS + 1;

    logic signed [SUM_BITS-1:0]            sum;
    logic signed [bfsp_pkg::DIST_BITS-1:0] cand;

    assign sum = SUM_BITS'(dist_a) + SUM_BITS'(weight);

    always_comb begin
        priority if (sum > SUM_BITS'(bfsp_pkg::DIST_MAX)) begin
            cand = bfsp_pkg::DIST_MAX;
        end else if (sum < SUM_BITS'(bfsp_pkg::DIST_MIN)) begin
            cand = bfsp_pkg::DIST_MIN;
        end else begin
            cand = sum[bfsp_pkg::DIST_BITS-1:0];
        end
    end

    // An unreached end vertex counts as infinitely far, so any real edge improves it.
    assign result.cand    = cand;
    assign result.improve = edge_ok && (!reach_b || (cand < dist_b));

endmodule

/* rtl/bellman_ford_shortest_path_unit.sv */
// Top level of the Bellman-Ford shortest path unit.
// Depends on bfsp_pkg and bfsp_alu.
//
// A load transfer writes one edge weight and the unit stays ready for the next transfer.
// A run transfer occupies the unit until its results are delivered: one shared
// add/compare unit visits every edge of the 16x16 matrix in row then column order, each
// edge as a registered memory read, then evaluate and write back, over 15 relaxation
// passes and one check pass. Then 16 results follow, each through the out read, load
// and wait states, with the wait state held while the consumer stalls, or one
// flagged result as soon as the check pass finds a negative cycle. Vertices that are
// not reached report the largest positive distance and no parent.
module bellman_ford_shortest_path_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bfsp_pkg::in_item_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bfsp_pkg::out_item_t  m_payload
);

    localparam int N  = bfsp_pkg::NUM_VERTICES;
    localparam int VB = bfsp_pkg::VERT_BITS;
    localparam int DB = bfsp_pkg::DIST_BITS;
    localparam int WB = bfsp_pkg::WEIGHT_BITS;

    bfsp_pkg::state_t state_reg, state_next;

    logic [VB-1:0] i_reg;
    logic [VB-1:0] j_reg;
    logic [VB-1:0] pass_reg;
    logic          check_reg;

    logic signed [WB-1:0] wmem [bfsp_pkg::NUM_EDGES];
    logic [bfsp_pkg::NUM_EDGES-1:0] wvalid_reg;
    logic signed [DB-1:0] dmem [N];
    logic [VB-1:0]        pmem [N];
    logic [N-1:0]         reach_reg;
    logic [N-1:0]         pvalid_reg;

    logic signed [WB-1:0] w_rd_reg;
    logic signed [DB-1:0] da_rd_reg;
    logic signed [DB-1:0] db_rd_reg;

    bfsp_pkg::out_item_t  out_reg;
    bfsp_pkg::alu_result_t alu_res;

    logic                  in_xfer;
    logic                  load_xfer;
    logic                  run_xfer;
    logic                  edge_ok;
    logic                  last_edge;
    logic                  relax_wr;
    logic                  cycle_hit;
    logic [bfsp_pkg::EDGE_BITS-1:0] edge_idx;

    assign edge_idx  = {i_reg, j_reg};
    assign in_xfer   = s_valid && s_ready;
    assign load_xfer = in_xfer && (s_payload.opcode == bfsp_pkg::OP_LOAD)
                       && (int'(s_payload.row) < N) && (int'(s_payload.col) < N);
    assign run_xfer  = in_xfer && (s_payload.opcode == bfsp_pkg::OP_RUN);
    assign last_edge = (int'(i_reg) == N - 1) && (int'(j_reg) == N - 1);
    assign edge_ok   = reach_reg[i_reg] && wvalid_reg[edge_idx] && (w_rd_reg != '0);

    bfsp_alu u_alu (
        .dist_a  (da_rd_reg),
        .dist_b  (db_rd_reg),
        .weight  (w_rd_reg),
        .edge_ok (edge_ok),
        .reach_b (reach_reg[j_reg]),
        .result  (alu_res)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfsp_pkg::ST_IDLE: begin
                if (run_xfer) state_next = bfsp_pkg::ST_READ;
            end
            bfsp_pkg::ST_READ: begin
                state_next = bfsp_pkg::ST_EVAL;
            end
            bfsp_pkg::ST_EVAL: begin
                priority if (check_reg && alu_res.improve) begin
                    state_next = bfsp_pkg::ST_OUT_WAIT;
                end else if (check_reg && last_edge) begin
                    state_next = bfsp_pkg::ST_OUT_READ;
                end else begin
                    state_next = bfsp_pkg::ST_READ;
                end
            end
            bfsp_pkg::ST_OUT_READ: begin
                state_next = bfsp_pkg::ST_OUT_LOAD;
            end
            bfsp_pkg::ST_OUT_LOAD: begin
                state_next = bfsp_pkg::ST_OUT_WAIT;
            end
            bfsp_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    state_next = out_reg.last ? bfsp_pkg::ST_IDLE : bfsp_pkg::ST_OUT_READ;
                end
            end
            default: state_next = bfsp_pkg::ST_IDLE;
        endcase
    end

    // Outputs and strobes.
    always_comb begin
        s_ready   = (state_reg == bfsp_pkg::ST_IDLE);
        m_valid   = (state_reg == bfsp_pkg::ST_OUT_WAIT);
        cycle_hit = (state_reg == bfsp_pkg::ST_EVAL) && check_reg && alu_res.improve;
        relax_wr  = (state_reg == bfsp_pkg::ST_EVAL) && !check_reg && alu_res.improve;
    end

    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfsp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Edge and pass counters. During result delivery i_reg walks the vertices.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg     <= '0;
            j_reg     <= '0;
            pass_reg  <= '0;
            check_reg <= 1'b0;
        end else begin
            if (run_xfer) begin
                i_reg     <= '0;
                j_reg     <= '0;
                pass_reg  <= '0;
                check_reg <= 1'b0;
            end else if ((state_reg == bfsp_pkg::ST_EVAL) && !cycle_hit) begin
                if (int'(j_reg) == N - 1) begin
                    j_reg <= '0;
                    if (int'(i_reg) == N - 1) begin
                        i_reg <= '0;
                        if (!check_reg) begin
                            pass_reg <= pass_reg + 1'b1;
                            if (int'(pass_reg) == N - 2) check_reg <= 1'b1;
                        end
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end else if ((state_reg == bfsp_pkg::ST_OUT_WAIT) && m_ready && !out_reg.last) begin
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    // Per-vertex flags and per-edge load flags; a run start clears the vertex flags of the previous run.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg  <= '0;
            pvalid_reg <= '0;
            wvalid_reg <= '0;
        end else begin
            if (load_xfer) begin
                wvalid_reg[{s_payload.row, s_payload.col}] <= 1'b1;
            end
            if (run_xfer) begin
                pvalid_reg <= '0;
                reach_reg  <= '0;
                if (int'(s_payload.source_vertex) < N) begin
                    reach_reg[s_payload.source_vertex] <= 1'b1;
                end
            end else if (relax_wr) begin
                reach_reg[j_reg]  <= 1'b1;
                pvalid_reg[j_reg] <= 1'b1;
            end
        end
    end

    // Weight matrix: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (load_xfer) begin
            wmem[{s_payload.row, s_payload.col}] <= s_payload.weight;
        end
        w_rd_reg <= wmem[edge_idx];
    end

    // Distance store: one write port, registered reads at the start and end vertex.
    always_ff @(posedge aclk) begin
        if (run_xfer && (int'(s_payload.source_vertex) < N)) begin
            dmem[s_payload.source_vertex] <= '0;
        end else if (relax_wr) begin
            dmem[j_reg] <= alu_res.cand;
        end
        da_rd_reg <= dmem[i_reg];
        db_rd_reg <= dmem[j_reg];
    end

    // Parent store and result register.
    always_ff @(posedge aclk) begin
        if (relax_wr) begin
            pmem[j_reg] <= i_reg;
        end
        if (cycle_hit) begin
            out_reg                <= '0;
            out_reg.negative_cycle <= 1'b1;
            out_reg.last           <= 1'b1;
        end else if (state_reg == bfsp_pkg::ST_OUT_LOAD) begin
            out_reg.vertex         <= i_reg;
            out_reg.distance       <= reach_reg[i_reg] ? da_rd_reg : bfsp_pkg::DIST_MAX;
            out_reg.reachable      <= reach_reg[i_reg];
            out_reg.parent         <= pvalid_reg[i_reg] ? pmem[i_reg] : '0;
            out_reg.has_parent     <= pvalid_reg[i_reg];
            out_reg.negative_cycle <= 1'b0;
            out_reg.last           <= (int'(i_reg) == N - 1);
        end
    end

endmodule

/* rtl/bfsp_checker.sv */
// Port-level checker for the Bellman-Ford shortest path unit, with its bind.
// Depends on bfsp_pkg and bellman_ford_shortest_path_unit.
module bfsp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bfsp_pkg::in_item_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input bfsp_pkg::out_item_t m_payload
);

    // The unit never takes input while a result is pending.
    a_busy_while_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result is pending");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("result dropped or changed while stalled");

    // A negative cycle report always closes the run.
    a_cycle_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.negative_cycle) |-> m_payload.last)
        else $error("negative cycle result not marked last");

    // After the final result of a run the unit returns to accepting input.
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.last) |=> (!m_valid && s_ready))
        else $error("unit did not go idle after the last result");

    // After a load transfer the unit is ready again in the next cycle.
    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.opcode == bfsp_pkg::OP_LOAD)) |=> s_ready)
        else $error("unit busy after a load transfer");

endmodule

bind bellman_ford_shortest_path_unit bfsp_checker u_bfsp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
